[src/cft_pkg.sv]
`default_nettype none
package cft_pkg;
  localparam int unsigned NumSourcesDefault = 4;
  localparam int unsigned PpqnDefault = 192;
  localparam logic [31:0] SilenceLimitUs = 32'd500000;
  localparam logic [31:0] DefaultNumerator = 32'd500000;

  typedef enum logic [3:0] {
    ActTimer = 4'd0, ActExtTick = 4'd1, ActExtStart = 4'd2, ActExtStop = 4'd3,
    ActExtCont = 4'd4, ActExtReset = 4'd5, ActMStart = 4'd6, ActMStop = 4'd7,
    ActMCont = 4'd8, ActMReset = 4'd9
  } action_e;

  typedef enum logic [2:0] {
    EvNone = 3'd0, EvStart = 3'd1, EvStop = 3'd2, EvCont = 3'd3, EvReset = 3'd4
  } event_e;

  typedef enum logic [1:0] {
    StIdle = 2'd0, StMaster = 2'd1, StSlave = 2'd2
  } run_e;

  typedef enum logic [1:0] {
    ModeAuto = 2'd0, ModeMaster = 2'd1, ModeSlave = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    RegMode = 3'd0, RegMask = 3'd1, RegDiv0 = 3'd2, RegDiv1 = 3'd3,
    RegDiv2 = 3'd4, RegDiv3 = 3'd5, RegTimer = 3'd6
  } reg_e;

  typedef struct packed {
    logic [3:0] action;
    logic [1:0] source;
  } item_t;

  typedef struct packed {
    logic        tick_valid;
    logic [31:0] tick_number;
    logic        midi_clock;
    logic [2:0]  transport_event;
    logic        run_level;
    logic        reset_level;
    logic [1:0]  run_state;
    logic [1:0]  active_source;
  } result_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;     // latch item, do the part that needs no division
    logic mul_go;   // compute default period
    logic div_go;   // start period/divisor division
    logic finish;   // apply scheduling after division
    logic emit;     // publish result
  } cmd_t;

  typedef struct packed {
    logic need_math; // accepted item is a followed ext tick
    logic div_busy;
  } status_t;
endpackage
`default_nettype wire

[src/cft_if.sv]
`default_nettype none
interface cft_if #(parameter int unsigned W = 1) (input wire logic clk_i);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[src/cft_divider.sv]
`default_nettype none
module cft_divider (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [31:0] dividend_i,
  input  wire logic [7:0]  divisor_i,
  output logic             busy_o,
  output logic [31:0]      quotient_o
);
  logic [31:0] quo_q, quo_d;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  dsr_q;
  logic [5:0]  cnt_q, cnt_d;
  logic [8:0]  trial;

  // restoring division, one quotient bit per cycle
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    trial = {rem_q[7:0], quo_q[31]};
    if (cnt_q != 6'd0) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = trial - {1'b0, dsr_q};
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 6'd0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= 9'd0;
      dsr_q <= divisor_i;
    end else begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = (cnt_q != 6'd0);
  assign quotient_o = quo_q;
endmodule
`default_nettype wire

[src/cft_datapath.sv]
`default_nettype none
module cft_datapath #(
  parameter int unsigned NumSources = cft_pkg::NumSourcesDefault,
  parameter int unsigned Ppqn = cft_pkg::PpqnDefault
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire cft_pkg::cmd_t    cmd_i,
  output cft_pkg::status_t      status_o,
  input  wire cft_pkg::item_t   item_i,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_index_i,
  input  wire logic [31:0]      cfg_data_i,
  output cft_pkg::result_t      result_o
);
  import cft_pkg::*;

  localparam int unsigned StepRaw = Ppqn / 24;
  localparam int unsigned Step = (StepRaw == 0) ? 1 : StepRaw;
  localparam logic [4:0] StepLast = 5'(Step - 1);

  logic [1:0] mode_q;
  logic [3:0] mask_q;
  logic [7:0] div_q [4];
  logic [9:0] tper_q;

  logic [1:0]  rs_q, rs_d;
  logic [1:0]  fs_q, fs_d;
  logic [31:0] tc_q, tc_d;
  logic [4:0]  ph_q, ph_d;
  logic [8:0]  pend_q, pend_d;
  logic [31:0] el_q, el_d, last_q, last_d, ext_q, ext_d, sub_q, sub_d, nxt_q, nxt_d;
  logic        run_q, run_d, rst_q, rst_d;
  logic [2:0]  ev_d;
  logic        tv_d, mc_d;
  logic [31:0] tn_d;
  result_t     res_q;

  logic        en;
  logic [1:0]  s;
  logic [7:0]  d;
  logic [7:0]  d_fs;
  logic [9:0]  pend_sum;
  logic        math_q, math_d;
  logic [31:0] prod_q;
  logic [31:0] dividend;
  logic        dbusy;
  logic [31:0] quo;
  logic [31:0] period;
  logic [31:0] sp;
  logic [31:0] def_tab [256];

  assign s = item_i.source;
  assign en = (32'(s) < 32'(NumSources)) && mask_q[s];
  assign d = (div_q[s] == 8'd0) ? 8'd1 : div_q[s];
  // the followed source stays fixed while a tick is being scheduled
  assign d_fs = (div_q[fs_q] == 8'd0) ? 8'd1 : div_q[fs_q];
  assign pend_sum = {1'b0, pend_q} + {2'b00, d};

  // default period (120 BPM) per divisor value, constant table
  for (genvar g = 0; g < 256; g++) begin : g_def
    assign def_tab[g] = 32'((40'(DefaultNumerator) * 40'(g)) / 40'(Ppqn));
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeAuto;
      mask_q <= 4'hf;
      div_q[0] <= 8'd8; div_q[1] <= 8'd8; div_q[2] <= 8'd8; div_q[3] <= 8'd8;
      tper_q <= 10'd100;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegMode:  mode_q <= cfg_data_i[1:0];
        RegMask:  mask_q <= cfg_data_i[3:0];
        RegDiv0:  div_q[0] <= cfg_data_i[7:0];
        RegDiv1:  div_q[1] <= cfg_data_i[7:0];
        RegDiv2:  div_q[2] <= cfg_data_i[7:0];
        RegDiv3:  div_q[3] <= cfg_data_i[7:0];
        RegTimer: tper_q <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign period = el_q - last_q;
  assign dividend = ext_q;

  cft_divider u_div (
    .clk_i, .rst_ni,
    .start_i(cmd_i.div_go),
    .dividend_i(dividend),
    .divisor_i(d_fs),
    .busy_o(dbusy),
    .quotient_o(quo)
  );

  assign sp = (quo == 32'd0) ? 32'd1 : quo;

  always_comb begin
    rs_d = rs_q; fs_d = fs_q; tc_d = tc_q; ph_d = ph_q; pend_d = pend_q;
    el_d = el_q; last_d = last_q; ext_d = ext_q; sub_d = sub_q; nxt_d = nxt_q;
    run_d = run_q; rst_d = rst_q;
    ev_d = EvNone; tv_d = 1'b0; tn_d = 32'd0; mc_d = 1'b0;
    math_d = 1'b0;
    if (cmd_i.load) begin
      case (item_i.action)
        ActTimer: begin
          if (rs_q == StMaster) begin
            rst_d = 1'b0; tv_d = 1'b1; tn_d = tc_q;
            mc_d = (ph_q == 5'd0); tc_d = tc_q + 32'd1;
            // phase of tick_count modulo the MIDI clock step
            ph_d = (tc_q == 32'hffff_ffff || ph_q == StepLast) ? 5'd0 : ph_q + 5'd1;
          end else if (rs_q == StSlave) begin
            el_d = el_q + 32'(tper_q);
            if (pend_q != 9'd0 && el_d >= nxt_q) begin
              rst_d = 1'b0; tv_d = 1'b1; tn_d = tc_q;
              mc_d = (ph_q == 5'd0); tc_d = tc_q + 32'd1;
              ph_d = (tc_q == 32'hffff_ffff || ph_q == StepLast) ? 5'd0 : ph_q + 5'd1;
              pend_d = pend_q - 9'd1;
              nxt_d = nxt_q + sub_q;
            end
            if (mode_q != ModeMaster && mode_q != ModeSlave &&
                (el_d - last_q) > SilenceLimitUs &&
                (32'(fs_q) < 32'(NumSources)) && mask_q[fs_q]) begin
              rs_d = StIdle; ev_d = EvReset; run_d = 1'b0; rst_d = 1'b1;
            end
          end
        end
        ActExtTick: begin
          if (en && rs_q == StSlave && fs_q == s) begin
            math_d = 1'b1;
            pend_d = (pend_sum > {1'b0, d, 1'b0}) ? {d, 1'b0} : pend_sum[8:0];
          end
        end
        ActExtStart: begin
          if (en && rs_q != StMaster && mode_q != ModeMaster &&
              !(rs_q == StSlave && fs_q != s)) begin
            rs_d = StSlave; fs_d = s; ev_d = EvStart; run_d = 1'b1; rst_d = 1'b1;
            tc_d = 32'd0; ph_d = 5'd0; pend_d = 9'd0;
            nxt_d = 32'd0; ext_d = 32'd0; el_d = 32'd0; last_d = 32'd0;
          end
        end
        ActExtStop: begin
          if (en && rs_q == StSlave && mode_q != ModeMaster && fs_q == s) begin
            rs_d = StIdle; ev_d = EvStop; run_d = 1'b0; rst_d = 1'b0;
          end
        end
        ActExtCont: begin
          if (en && rs_q == StIdle && mode_q != ModeMaster) begin
            rs_d = StSlave; fs_d = s; ev_d = EvCont; run_d = 1'b1; rst_d = 1'b0;
            nxt_d = 32'd0; ext_d = 32'd0; el_d = 32'd0; last_d = 32'd0;
          end
        end
        ActExtReset: begin
          if (en && rs_q != StMaster && mode_q != ModeMaster &&
              !(rs_q == StSlave && fs_q != s)) begin
            rs_d = StIdle; ev_d = EvReset; run_d = 1'b0; rst_d = 1'b1;
          end
        end
        ActMStart: begin
          if (rs_q != StSlave && mode_q != ModeSlave) begin
            rs_d = StMaster; ev_d = EvStart; run_d = 1'b1; rst_d = 1'b1;
            tc_d = 32'd0; ph_d = 5'd0; pend_d = 9'd0;
          end
        end
        ActMStop: begin
          if (rs_q == StMaster) begin
            rs_d = StIdle; ev_d = EvStop; run_d = 1'b0; rst_d = 1'b0;
          end
        end
        ActMCont: begin
          if (rs_q == StIdle && mode_q != ModeSlave) begin
            rs_d = StMaster; ev_d = EvCont; run_d = 1'b1; rst_d = 1'b0;
          end
        end
        ActMReset: begin
          if (rs_q != StSlave && mode_q != ModeSlave) begin
            rs_d = StIdle; ev_d = EvReset; run_d = 1'b0; rst_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    if (cmd_i.mul_go) begin
      // period update ahead of the division
      if (ext_q == 32'd0) ext_d = prod_q;
      if (period != 32'd0 && last_q != 32'd0) ext_d = period;
      if (ext_q != 32'd0 && !(period != 32'd0 && last_q != 32'd0)) ext_d = ext_q;
    end
    if (cmd_i.finish) begin
      sub_d = sp;
      if (nxt_q == 32'd0 || el_q > nxt_q + sp) nxt_d = el_q + sp;
      else nxt_d = nxt_q + sp;
      last_d = el_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= StIdle; fs_q <= 2'd0; tc_q <= 32'd0; ph_q <= 5'd0; pend_q <= 9'd0;
      el_q <= 32'd0; last_q <= 32'd0; ext_q <= 32'd0; sub_q <= 32'd0;
      nxt_q <= 32'd0; run_q <= 1'b0; rst_q <= 1'b0; math_q <= 1'b0;
    end else begin
      rs_q <= rs_d; fs_q <= fs_d; tc_q <= tc_d; ph_q <= ph_d; pend_q <= pend_d;
      el_q <= el_d; last_q <= last_d; ext_q <= ext_d; sub_q <= sub_d;
      nxt_q <= nxt_d; run_q <= run_d; rst_q <= rst_d;
      if (cmd_i.load) math_q <= math_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) prod_q <= def_tab[d];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      res_q.tick_valid <= tv_d;
      res_q.tick_number <= tn_d;
      res_q.midi_clock <= mc_d;
      res_q.transport_event <= ev_d;
    end
    if (cmd_i.emit) begin
      res_q.run_level <= run_q;
      res_q.reset_level <= rst_q;
      res_q.run_state <= rs_q;
      res_q.active_source <= (rs_q == StSlave) ? fs_q : 2'd0;
    end
  end

  assign result_o = res_q;
  assign status_o.need_math = math_q;
  assign status_o.div_busy = dbusy;
endmodule
`default_nettype wire

[src/cft_ctrl.sv]
`default_nettype none
module cft_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire cft_pkg::status_t status_i,
  output cft_pkg::cmd_t      cmd_o
);
  import cft_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SDecide = 3'd1;
  localparam logic [2:0] SMul = 3'd2;
  localparam logic [2:0] SDivGo = 3'd3;
  localparam logic [2:0] SDivWait = 3'd4;
  localparam logic [2:0] SEmit = 3'd5;
  localparam logic [2:0] SOut = 3'd6;

  logic [2:0] st_q, st_d;
  logic       acc;

  assign in_ready_o = (st_q == SIdle);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (st_q == SOut);

  always_comb begin
    st_d = st_q;
    cmd_o = '0;
    case (st_q)
      SIdle: if (acc) begin
        cmd_o.load = 1'b1;
        st_d = SDecide;
      end
      SDecide: st_d = status_i.need_math ? SMul : SEmit;
      SMul: begin
        cmd_o.mul_go = 1'b1;
        st_d = SDivGo;
      end
      SDivGo: begin
        cmd_o.div_go = 1'b1;
        st_d = SDivWait;
      end
      SDivWait: if (!status_i.div_busy) begin
        cmd_o.finish = 1'b1;
        st_d = SEmit;
      end
      SEmit: begin
        cmd_o.emit = 1'b1;
        st_d = SOut;
      end
      SOut: if (out_ready_i) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= SIdle;
    else st_q <= st_d;
  end
endmodule
`default_nettype wire

[src/clock_follower_transport_core.sv]
`default_nettype none
// Transport and clock multiplier core for a sequencer.
// Channels: in_if carries one item (action, source); out_if returns exactly one
// result item per input item; cfg_if writes registers (index 0 mode, 1 source
// mask, 2..5 divisors, 6 timer period in us).
// Sequence: most items go from accept through the decide and emit states to
// result valid; an external clock tick of the followed source also runs the
// shared restoring divider (measured period over divisor) before emit.
// Flow: one item at a time; no new item is accepted before the previous result
// is taken, and the divider path is the slowest.
// Reset: transport idle, all counters and time base zero, registers at their
// reset values; no clearing pass is needed.
// Stall: the result holds in the output register until taken; no new item is
// accepted until then. Configuration writes are taken at any time and are
// meant for idle periods only.
module clock_follower_transport_core #(
  parameter int unsigned NumSources = cft_pkg::NumSourcesDefault,
  parameter int unsigned Ppqn = cft_pkg::PpqnDefault
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cft_if.sink      in_if,
  cft_if.source    out_if,
  cft_if.sink      cfg_if
);
  import cft_pkg::*;

  cmd_t    cmd;
  status_t status;
  result_t res;
  item_t   item;

  assign item = in_if.data;
  assign cfg_if.ready = 1'b1;

  cft_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid),
    .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid),
    .out_ready_i(out_if.ready),
    .status_i(status),
    .cmd_o(cmd)
  );

  cft_datapath #(.NumSources(NumSources), .Ppqn(Ppqn)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd),
    .status_o(status),
    .item_i(item),
    .cfg_we_i(cfg_if.valid),
    .cfg_index_i(cfg_if.data[34:32]),
    .cfg_data_i(cfg_if.data[31:0]),
    .result_o(res)
  );

  assign out_if.data = res;

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.mul_go, cmd.div_go, cmd.finish, cmd.emit}))
    else $error("more than one datapath command");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> !in_if.ready)
    else $error("input accepted while result pending");
  a_emit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_if.valid)
    else $error("result not presented after emit");
endmodule
`default_nettype wire
